FILE: hw/rtl/csvdp_pkg.sv
// Shared constants, types and byte codes for the CSV decimal field parser.
`default_nettype none

package csvdp_pkg;

   localparam int MAX_DIGITS = 5;
   localparam int NUM_AXES   = 4;

   localparam int BYTE_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int VALUE_W     = 17;
   localparam int AXIS_W      = 2;
   localparam int PROD_W      = VALUE_W + 4;
   localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int FIELD_IDX_W = $clog2(NUM_AXES + 1);

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

   typedef struct packed {
      logic               is_digit;
      logic               is_comma;
      logic               is_eol;
      logic [DIGIT_W-1:0] digit;
   } byte_class_type;

   typedef struct packed {
      logic               emit;
      logic [VALUE_W-1:0] field_value;
      logic [AXIS_W-1:0]  axis_index;
      logic               is_buttons;
   } result_type;

   typedef struct packed {
      logic [DIGIT_CNT_W-1:0] digit_count;
      logic [FIELD_IDX_W-1:0] field_index;
   } parse_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/csvdp_classify.sv
// Byte decoder: sorts a received byte into digit, comma, line end or other.
`default_nettype none

module csvdp_classify (
   input  wire logic [csvdp_pkg::BYTE_W-1:0] rx_byte,
   output csvdp_pkg::byte_class_type         byte_class
);

   logic [csvdp_pkg::BYTE_W-1:0] digit_offset;

   assign digit_offset = rx_byte - csvdp_pkg::CHAR_ZERO;

   always_comb begin
      byte_class.is_digit = (rx_byte >= csvdp_pkg::CHAR_ZERO) &&
                            (rx_byte <= csvdp_pkg::CHAR_NINE);
      byte_class.is_comma = (rx_byte == csvdp_pkg::CHAR_COMMA);
      byte_class.is_eol   = (rx_byte == csvdp_pkg::CHAR_LF) ||
                            (rx_byte == csvdp_pkg::CHAR_CR);
      byte_class.digit    = digit_offset[csvdp_pkg::DIGIT_W-1:0];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/csvdp_step.sv
// Parse state (accumulator, digit count, field index) and per-byte update.
`default_nettype none

module csvdp_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  csvdp_pkg::byte_class_type   byte_class,
   output csvdp_pkg::result_type       result,
   output csvdp_pkg::parse_status_type status
);

   logic [csvdp_pkg::VALUE_W-1:0]     accum_value_ff, accum_value_in;
   logic [csvdp_pkg::DIGIT_CNT_W-1:0] digit_count_ff, digit_count_in;
   logic [csvdp_pkg::FIELD_IDX_W-1:0] field_index_ff, field_index_in;

   logic [csvdp_pkg::PROD_W-1:0]  accum_wide;
   logic [csvdp_pkg::PROD_W-1:0]  next_wide;
   logic [csvdp_pkg::VALUE_W-1:0] next_value;
   logic                          have_digits;
   logic                          room_for_digit;
   logic                          axis_open;

   // accum*10 + digit, saturated at the field width
   assign accum_wide = csvdp_pkg::PROD_W'(accum_value_ff);
   assign next_wide  = (accum_wide << 3) + (accum_wide << 1) +
                       csvdp_pkg::PROD_W'(byte_class.digit);
   assign next_value = (next_wide > csvdp_pkg::PROD_W'(csvdp_pkg::VALUE_MAX)) ?
                       csvdp_pkg::VALUE_MAX : next_wide[csvdp_pkg::VALUE_W-1:0];

   assign have_digits    = (digit_count_ff != '0);
   assign room_for_digit = (digit_count_ff <
                            csvdp_pkg::DIGIT_CNT_W'(csvdp_pkg::MAX_DIGITS));
   assign axis_open      = (field_index_ff <
                            csvdp_pkg::FIELD_IDX_W'(csvdp_pkg::NUM_AXES));

   always_comb begin
      accum_value_in     = accum_value_ff;
      digit_count_in     = digit_count_ff;
      field_index_in     = field_index_ff;
      result.emit        = 1'b0;
      result.field_value = accum_value_ff;
      result.axis_index  = csvdp_pkg::AXIS_W'(field_index_ff);
      result.is_buttons  = 1'b0;

      if (byte_class.is_digit) begin
         if (room_for_digit) begin
            accum_value_in = next_value;
            digit_count_in = digit_count_ff + 1'b1;
         end
      end else if (byte_class.is_comma) begin
         if (have_digits) begin
            // drop values past the last axis slot
            if (axis_open) begin
               result.emit    = 1'b1;
               field_index_in = field_index_ff + 1'b1;
            end
            accum_value_in = '0;
            digit_count_in = '0;
         end
      end else if (byte_class.is_eol) begin
         if (have_digits) begin
            result.emit       = 1'b1;
            result.axis_index = '0;
            result.is_buttons = 1'b1;
            accum_value_in    = '0;
            digit_count_in    = '0;
            field_index_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_value_ff <= '0;
         digit_count_ff <= '0;
         field_index_ff <= '0;
      end else if (enable) begin
         accum_value_ff <= accum_value_in;
         digit_count_ff <= digit_count_in;
         field_index_ff <= field_index_in;
      end
   end

   assign status.digit_count = digit_count_ff;
   assign status.field_index = field_index_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/csv_decimal_field_parser_unit.sv
// An accepted item is held in the input register; any result it yields loads into the
// result register when that held item is consumed, which waits while the result stalls.
// Throughput: one item per cycle while the result is not stalled; the parse state and the
// result register update only at the edge that consumes the held item.
// Reset (synchronous, active high) empties both registers and clears the
// accumulator, digit count and field index; payload registers keep their value.
`default_nettype none

module csv_decimal_field_parser_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [csvdp_pkg::BYTE_W-1:0]        req_rx_byte,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [csvdp_pkg::VALUE_W-1:0]       rsp_field_value,
   output      logic [csvdp_pkg::AXIS_W-1:0]        rsp_axis_index,
   output      logic                                rsp_is_buttons
);

   logic                          in_valid_ff;
   logic [csvdp_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   csvdp_pkg::result_type         out_result_ff;

   logic                          out_free;
   logic                          consume;
   csvdp_pkg::byte_class_type     byte_class;
   csvdp_pkg::result_type         step_result;
   csvdp_pkg::parse_status_type   status;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign consume   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   csvdp_classify u_classify (
      .rx_byte    (in_byte_ff),
      .byte_class (byte_class)
   );

   csvdp_step u_step (
      .clock      (clock),
      .reset      (reset),
      .enable     (consume),
      .byte_class (byte_class),
      .result     (step_result),
      .status     (status)
   );

   // input register: refill whenever the held item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // result register: hold while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = consume && step_result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && step_result.emit) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_field_value = out_result_ff.field_value;
   assign rsp_axis_index  = out_result_ff.axis_index;
   assign rsp_is_buttons  = out_result_ff.is_buttons;

`ifndef SYNTHESIS
   a_field_index_bound : assert property (@(posedge clock) disable iff (reset)
      status.field_index <= csvdp_pkg::FIELD_IDX_W'(csvdp_pkg::NUM_AXES))
      else $error("field index past axis count");

   a_digit_count_bound : assert property (@(posedge clock) disable iff (reset)
      status.digit_count <= csvdp_pkg::DIGIT_CNT_W'(csvdp_pkg::MAX_DIGITS))
      else $error("digit count past limit");

   a_buttons_axis_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_buttons) |-> (rsp_axis_index == '0))
      else $error("button word with nonzero axis");

   a_emit_clears_digits : assert property (@(posedge clock) disable iff (reset)
      (consume && step_result.emit) |=> (status.digit_count == '0))
      else $error("digits not cleared after a result");

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("input stalled with no held item");
`endif

endmodule

`default_nettype wire
